>>> src/bzr_pkg.sv
// Shared constants and types for the cubic Bezier point evaluator.
package bzr_pkg;

   localparam int STEP_BITS_DEF   = 10;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int CSR_ADDR_W      = 3;

   // coordinate lanes
   localparam int COORD_X = 0;
   localparam int COORD_Y = 1;
   localparam int NUM_COORDS = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_P0_X = 3'd0,
      CSR_P0_Y = 3'd1,
      CSR_P1_X = 3'd2,
      CSR_P1_Y = 3'd3,
      CSR_P2_X = 3'd4,
      CSR_P2_Y = 3'd5,
      CSR_P3_X = 3'd6,
      CSR_P3_Y = 3'd7
   } csr_index_type;

endpackage

>>> src/bzr_coef.sv
// Control point registers and power-basis coefficient generation.
module bzr_coef #(
   parameter int COORD_WIDTH = bzr_pkg::COORD_WIDTH_DEF,
   parameter int COEF_W      = bzr_pkg::COORD_WIDTH_DEF + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bzr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [COORD_WIDTH-1:0]        csr_wdata,
   output logic signed [COEF_W-1:0]      coef_a [bzr_pkg::NUM_COORDS],
   output logic signed [COEF_W-1:0]      coef_b [bzr_pkg::NUM_COORDS],
   output logic signed [COEF_W-1:0]      coef_c [bzr_pkg::NUM_COORDS],
   output logic signed [COEF_W-1:0]      coef_d [bzr_pkg::NUM_COORDS]
);
   import bzr_pkg::*;

   logic signed [COORD_WIDTH-1:0] pt_ff [NUM_COORDS][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COORDS; k++) begin
            for (int i = 0; i < 4; i++) begin
               pt_ff[k][i] <= '0;
            end
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_P0_X: pt_ff[COORD_X][0] <= csr_wdata;
            CSR_P0_Y: pt_ff[COORD_Y][0] <= csr_wdata;
            CSR_P1_X: pt_ff[COORD_X][1] <= csr_wdata;
            CSR_P1_Y: pt_ff[COORD_Y][1] <= csr_wdata;
            CSR_P2_X: pt_ff[COORD_X][2] <= csr_wdata;
            CSR_P2_Y: pt_ff[COORD_Y][2] <= csr_wdata;
            CSR_P3_X: pt_ff[COORD_X][3] <= csr_wdata;
            CSR_P3_Y: pt_ff[COORD_Y][3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < NUM_COORDS; k++) begin : g_coord
      logic signed [COEF_W-1:0] p0, p1, p2, p3;
      logic signed [COEF_W-1:0] d12, s012, d01;
      logic signed [COEF_W-1:0] a_in, b_in, c_in;
      logic signed [COEF_W-1:0] a_ff, b_ff, c_ff, d_ff;

      assign p0 = COEF_W'(pt_ff[k][0]);
      assign p1 = COEF_W'(pt_ff[k][1]);
      assign p2 = COEF_W'(pt_ff[k][2]);
      assign p3 = COEF_W'(pt_ff[k][3]);

      // a = P3 - P0 + 3(P1 - P2), b = 3(P0 - 2P1 + P2), c = 3(P1 - P0)
      assign d12  = p1 - p2;
      assign s012 = p0 - (p1 <<< 1) + p2;
      assign d01  = p1 - p0;
      assign a_in = p3 - p0 + (d12 <<< 1) + d12;
      assign b_in = (s012 <<< 1) + s012;
      assign c_in = (d01 <<< 1) + d01;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_ff <= '0;
            b_ff <= '0;
            c_ff <= '0;
            d_ff <= '0;
         end else begin
            a_ff <= a_in;
            b_ff <= b_in;
            c_ff <= c_in;
            d_ff <= p0;
         end
      end

      assign coef_a[k] = a_ff;
      assign coef_b[k] = b_ff;
      assign coef_c[k] = c_ff;
      assign coef_d[k] = d_ff;
   end

endmodule

>>> src/bzr_horner.sv
// One registered Horner step: acc = prev * t + coef << shift, exact.
module bzr_horner #(
   parameter int IN_W   = 20,
   parameter int COEF_W = 20,
   parameter int T_W    = 11,
   parameter int SHIFT  = 10,
   parameter int OUT_W  = 32
) (
   input  logic                     clock,
   input  logic signed [IN_W-1:0]   h_prev,
   input  logic [T_W-1:0]           t_val,
   input  logic signed [COEF_W-1:0] coef,
   output logic signed [OUT_W-1:0]  h_next
);

   localparam int PROD_W = IN_W + T_W + 1;

   logic signed [PROD_W-1:0] prod;
   logic signed [OUT_W-1:0]  acc_in;
   logic signed [OUT_W-1:0]  acc_ff;

   assign prod   = h_prev * $signed({1'b0, t_val});
   assign acc_in = OUT_W'(prod) + (OUT_W'(coef) <<< SHIFT);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign h_next = acc_ff;

endmodule

>>> src/bzr_round.sv
// Round to nearest (ties up), drop the fraction and saturate to the output width.
module bzr_round #(
   parameter int IN_W  = 52,
   parameter int SHIFT = 30,
   parameter int OUT_W = 16
) (
   input  logic                    clock,
   input  logic signed [IN_W-1:0]  h_in,
   output logic signed [OUT_W-1:0] res
);

   localparam int Q_W = IN_W - SHIFT;

   logic [IN_W-1:0]          biased;
   logic [Q_W-1:0]           quot;
   logic [Q_W-OUT_W:0]       top_bits;
   logic                     fits;
   logic signed [OUT_W-1:0]  res_in;
   logic signed [OUT_W-1:0]  res_ff;

   assign biased   = h_in + (IN_W'(1) << (SHIFT - 1));
   assign quot     = biased[IN_W-1:SHIFT];
   assign top_bits = quot[Q_W-1:OUT_W-1];
   assign fits     = (&top_bits) | ~(|top_bits);

   always_comb begin
      if (fits) begin
         res_in = quot[OUT_W-1:0];
      end else if (quot[Q_W-1]) begin
         res_in = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         res_in = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

>>> src/cubic_bezier_point_evaluator.sv
// rsp_valid follows the t, three Horner and rounding registers (5-stage pipe).
// Throughput: one beat per cycle; each t goes through three registered Horner
// multiply-add stages per coordinate and a rounding/saturation stage.
// busy only follows reset, so start may be held high for a beat every cycle.
// Reset (synchronous, active high) clears valid bits and control points to zero.
// Results are strobed for one cycle; the receiver cannot stall them.
module cubic_bezier_point_evaluator #(
   parameter int STEP_BITS   = bzr_pkg::STEP_BITS_DEF,
   parameter int COORD_WIDTH = bzr_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request beats
   input  logic                           start,
   output logic                           busy,
   input  logic [STEP_BITS:0]             req_t_step,
   // result beats
   output logic                           rsp_valid,
   output logic signed [COORD_WIDTH-1:0]  rsp_x_out,
   output logic signed [COORD_WIDTH-1:0]  rsp_y_out,
   // control point registers
   input  logic                           csr_we,
   input  logic [bzr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [COORD_WIDTH-1:0]         csr_wdata
);
   import bzr_pkg::*;

   localparam int T_W    = STEP_BITS + 1;
   // coefficient magnitudes stay below 6 * 2^COORD_WIDTH
   localparam int COEF_W = COORD_WIDTH + 4;
   // exact Horner partial sums, scale 2^(k*STEP_BITS) after step k
   localparam int H1_W   = COORD_WIDTH + STEP_BITS + 6;
   localparam int H2_W   = COORD_WIDTH + 2 * STEP_BITS + 6;
   localparam int H3_W   = COORD_WIDTH + 3 * STEP_BITS + 6;
   localparam logic [T_W-1:0] T_ONE = {1'b1, {STEP_BITS{1'b0}}};

   logic                     accept;
   logic [T_W-1:0]           t_clamp;
   logic [T_W-1:0]           t_ff [3];
   logic [3:0]               vld_ff;
   logic                     rsp_valid_ff;

   logic signed [COEF_W-1:0] coef_a [NUM_COORDS];
   logic signed [COEF_W-1:0] coef_b [NUM_COORDS];
   logic signed [COEF_W-1:0] coef_c [NUM_COORDS];
   logic signed [COEF_W-1:0] coef_d [NUM_COORDS];
   logic signed [COORD_WIDTH-1:0] res [NUM_COORDS];

   // no backpressure anywhere in the pipe; only reset holds off requests
   assign busy   = reset;
   assign accept = start & ~busy;

   // t beyond one clamps to one (result is the last control point)
   assign t_clamp = (req_t_step[STEP_BITS] && (|req_t_step[STEP_BITS-1:0])) ?
                    T_ONE : req_t_step;

   always_ff @(posedge clock) begin
      t_ff[0] <= t_clamp;
      t_ff[1] <= t_ff[0];
      t_ff[2] <= t_ff[1];
   end

   // valid bits ride along with the data stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[2:0], accept};
         rsp_valid_ff <= vld_ff[3];
      end
   end

   bzr_coef #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_W      (COEF_W)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .coef_a    (coef_a),
      .coef_b    (coef_b),
      .coef_c    (coef_c),
      .coef_d    (coef_d)
   );

   for (genvar k = 0; k < NUM_COORDS; k++) begin : g_lane
      logic signed [H1_W-1:0] h1;
      logic signed [H2_W-1:0] h2;
      logic signed [H3_W-1:0] h3;

      // h1 = a*t + b*S
      bzr_horner #(
         .IN_W (COEF_W), .COEF_W (COEF_W), .T_W (T_W),
         .SHIFT (STEP_BITS), .OUT_W (H1_W)
      ) u_step1 (
         .clock (clock), .h_prev (coef_a[k]), .t_val (t_ff[0]),
         .coef (coef_b[k]), .h_next (h1)
      );

      // h2 = h1*t + c*S^2
      bzr_horner #(
         .IN_W (H1_W), .COEF_W (COEF_W), .T_W (T_W),
         .SHIFT (2 * STEP_BITS), .OUT_W (H2_W)
      ) u_step2 (
         .clock (clock), .h_prev (h1), .t_val (t_ff[1]),
         .coef (coef_c[k]), .h_next (h2)
      );

      // h3 = h2*t + d*S^3
      bzr_horner #(
         .IN_W (H2_W), .COEF_W (COEF_W), .T_W (T_W),
         .SHIFT (3 * STEP_BITS), .OUT_W (H3_W)
      ) u_step3 (
         .clock (clock), .h_prev (h2), .t_val (t_ff[2]),
         .coef (coef_d[k]), .h_next (h3)
      );

      bzr_round #(
         .IN_W (H3_W), .SHIFT (3 * STEP_BITS), .OUT_W (COORD_WIDTH)
      ) u_round (
         .clock (clock), .h_in (h3), .res (res[k])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = res[COORD_X];
   assign rsp_y_out = res[COORD_Y];

endmodule

>>> src/bzr_checker.sv
// Port-level checks for the cubic Bezier point evaluator, bound to the top level.
module bzr_checker #(
   parameter int STEP_BITS   = bzr_pkg::STEP_BITS_DEF,
   parameter int COORD_WIDTH = bzr_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [STEP_BITS:0]            req_t_step,
   input logic                          rsp_valid,
   input logic signed [COORD_WIDTH-1:0] rsp_x_out,
   input logic signed [COORD_WIDTH-1:0] rsp_y_out
);

   // every accepted beat yields a result when it leaves the pipe
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted beat produced no result");

   // no result without a matching accepted beat
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result strobe without a matching request");

   // pipe comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // an accepted request carries a known parameter
   a_known_request: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown(req_t_step))
      else $error("request beat with unknown t_step");

   // a strobed result carries known coordinates
   a_known_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_x_out, rsp_y_out}))
      else $error("result beat with unknown coordinates");

endmodule

bind cubic_bezier_point_evaluator bzr_checker #(
   .STEP_BITS   (STEP_BITS),
   .COORD_WIDTH (COORD_WIDTH)
) u_bzr_checker (.*);
